### hw/rtl/etbc_pkg.sv
`default_nettype none

package etbc_pkg;

  // token kinds on the result channel
  typedef enum logic [2:0] {
    TK_NUM_CHAR = 3'd0,
    TK_NUM_END  = 3'd1,
    TK_OPERATOR = 3'd2,
    TK_OPEN     = 3'd3,
    TK_CLOSE    = 3'd4,
    TK_END      = 3'd5,
    TK_INVALID  = 3'd6
  } tok_kind_t;

  // bracket status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_OPEN  = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_OVERFLOW = 2'd3
  } tok_status_t;

  // one result item
  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  chr;
    logic        dec;
    logic [1:0]  prec;
    tok_status_t status;
    logic [6:0]  depth;
    logic        last;
  } token_t;

  // shift control for the bracket cell chain
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] code;
  } stk_ctl_t;

  // result queue size
  localparam int QUEUE_DEPTH = 4;
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  // operator precedence ranks
  localparam logic [1:0] PREC_EXP = 2'd0;
  localparam logic [1:0] PREC_MUL = 2'd1;
  localparam logic [1:0] PREC_ADD = 2'd2;

  // bracket codes held in the cells
  localparam logic [1:0] BR_ROUND  = 2'd0;
  localparam logic [1:0] BR_SQUARE = 2'd1;
  localparam logic [1:0] BR_CURLY  = 2'd2;

  // character codes
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [7:0] DEC_POINT_RESET = 8'd46;

  // build a result item, last flag cleared
  function automatic token_t mk_tok(tok_kind_t kind, logic [7:0] chr, logic dec,
                                    logic [1:0] prec, tok_status_t status,
                                    logic [6:0] depth);
    token_t t;
    t.kind   = kind;
    t.chr    = chr;
    t.dec    = dec;
    t.prec   = prec;
    t.status = status;
    t.depth  = depth;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/etbc_cell.sv
`default_nettype none

module etbc_cell (
  input  wire                 clk,
  input  etbc_pkg::stk_ctl_t  ctl,
  input  wire  [1:0]          above_code,
  input  wire  [1:0]          below_code,
  output logic [1:0]          code_r
);

  logic [1:0] code_nxt;

  // push takes the entry from above, pop from below
  always_comb begin
    code_nxt = code_r;
    if (ctl.push) begin
      code_nxt = above_code;
    end else if (ctl.pop) begin
      code_nxt = below_code;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/etbc_outq.sv
`default_nettype none

module etbc_outq (
  input  wire                clk,
  input  wire                rst_n,
  input  wire  [1:0]         push_n,
  input  etbc_pkg::token_t   push_a,
  input  etbc_pkg::token_t   push_b,
  output logic               room,
  output logic               out_valid,
  input  wire                out_ready,
  output etbc_pkg::token_t   out_tok
);

  localparam int QD  = etbc_pkg::QUEUE_DEPTH;
  localparam int QCW = etbc_pkg::QCW;

  etbc_pkg::token_t slot_r   [QD];
  etbc_pkg::token_t slot_nxt [QD];
  logic [QCW-1:0]   cnt_r;
  logic [QCW-1:0]   cnt_nxt;
  logic [QCW-1:0]   base;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_tok   = slot_r[0];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= QCW'(QD - 2));
  assign base      = cnt_r - QCW'(pop);
  assign cnt_nxt   = base + QCW'(push_n);

  // shift toward the head on a pop, then append new requests
  always_comb begin
    for (int i = 0; i < QD; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QD - 1; i++) begin
        slot_nxt[i] = slot_r[i + 1];
      end
    end
    for (int i = 0; i < QD; i++) begin
      if ((push_n != 2'd0) && (QCW'(i) == base)) begin
        slot_nxt[i] = push_a;
      end
      if ((push_n == 2'd2) && (QCW'(i) == base + QCW'(1))) begin
        slot_nxt[i] = push_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/expression_tokenizer_bracket_check.sv
`default_nettype none

// channel   ports                     direction  item
// --------  ------------------------  ---------  -------------------------------
// input     in_valid / in_ready       in         one text byte and end marker
// result    out_valid / out_ready     out        one token with status and depth
// config    cfg_wr_en / cfg_wr_data   in         decimal point byte, no wait
//
// A byte is decoded in the cycle it is taken and its tokens, up to two, go into
// a four-entry result queue. The result port drains one token per cycle while
// out_ready is high. in_ready is high while the queue holds two tokens or fewer.
// Reset is synchronous: line state, queue and decimal point byte reset; the
// bracket cells hold data only and are not reset.

module expression_tokenizer_bracket_check #(
  parameter int STACK_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_ch,
  input  wire         in_is_eof,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_token_kind,
  output logic [7:0]  out_token_char,
  output logic        out_number_is_decimal,
  output logic [1:0]  out_precedence,
  output logic [1:0]  out_status,
  output logic [6:0]  out_nesting_depth,
  output logic        out_last,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = CW + 7;

  // line state
  logic          started_r, started_nxt;
  logic          num_open_r, num_open_nxt;
  logic          dec_seen_r, dec_seen_nxt;
  logic          halted_r, halted_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    dec_pt_r;

  etbc_pkg::stk_ctl_t stk_ctl;
  logic [1:0]         cell_code [STACK_DEPTH];

  etbc_pkg::token_t tok_pre, tok_nc, tok_main, q_a, q_b, out_tok;
  logic             pre_v, nc_v, main_v;
  logic [1:0]       push_n;
  logic             room;
  logic             in_acc;

  // byte classes
  logic       is_end, is_space, is_letter, is_ignored;
  logic       is_op, is_num, is_open, is_close;
  logic [1:0] op_prec, br_code;
  logic       full;

  function automatic logic [6:0] to_depth(logic [CW-1:0] c);
    logic [DW-1:0] wide;
    wide = DW'(c);
    return wide[6:0];
  endfunction

  assign in_ready = room;
  assign in_acc   = in_valid && in_ready;

  // classify the incoming byte
  always_comb begin
    is_end    = in_is_eof || (in_ch == etbc_pkg::CH_LF);
    is_space  = (in_ch == etbc_pkg::CH_SPACE);
    is_letter = ((in_ch >= etbc_pkg::CH_LC_A) && (in_ch <= etbc_pkg::CH_LC_Z)) ||
                ((in_ch >= etbc_pkg::CH_UC_A) && (in_ch <= etbc_pkg::CH_UC_Z));
    is_ignored = !in_is_eof && (is_space || is_letter);
    is_op     = 1'b1;
    op_prec   = etbc_pkg::PREC_EXP;
    priority if (in_ch == etbc_pkg::CH_CARET) begin
      op_prec = etbc_pkg::PREC_EXP;
    end else if ((in_ch == etbc_pkg::CH_STAR) || (in_ch == etbc_pkg::CH_SLASH)) begin
      op_prec = etbc_pkg::PREC_MUL;
    end else if ((in_ch == etbc_pkg::CH_PLUS) || (in_ch == etbc_pkg::CH_MINUS)) begin
      op_prec = etbc_pkg::PREC_ADD;
    end else begin
      is_op = 1'b0;
    end
    is_num = ((in_ch >= etbc_pkg::CH_ZERO) && (in_ch <= etbc_pkg::CH_NINE)) ||
             (in_ch == dec_pt_r);
    is_open  = 1'b0;
    is_close = 1'b0;
    br_code  = etbc_pkg::BR_ROUND;
    priority if (in_ch == etbc_pkg::CH_LPAREN) begin
      is_open = 1'b1;
    end else if (in_ch == etbc_pkg::CH_LSQ) begin
      is_open = 1'b1;
      br_code = etbc_pkg::BR_SQUARE;
    end else if (in_ch == etbc_pkg::CH_LCURLY) begin
      is_open = 1'b1;
      br_code = etbc_pkg::BR_CURLY;
    end else if (in_ch == etbc_pkg::CH_RPAREN) begin
      is_close = 1'b1;
    end else if (in_ch == etbc_pkg::CH_RSQ) begin
      is_close = 1'b1;
      br_code  = etbc_pkg::BR_SQUARE;
    end else if (in_ch == etbc_pkg::CH_RCURLY) begin
      is_close = 1'b1;
      br_code  = etbc_pkg::BR_CURLY;
    end else begin
      is_open = 1'b0;
    end
    full = (cnt_r >= CW'(STACK_DEPTH));
  end

  // token generation and line state update
  always_comb begin
    started_nxt  = started_r;
    num_open_nxt = num_open_r;
    dec_seen_nxt = dec_seen_r;
    halted_nxt   = halted_r;
    cnt_nxt      = cnt_r;
    stk_ctl      = '0;
    stk_ctl.code = br_code;
    pre_v        = 1'b0;
    nc_v         = 1'b0;
    main_v       = 1'b0;
    tok_pre  = etbc_pkg::mk_tok(etbc_pkg::TK_OPEN, etbc_pkg::CH_LPAREN, 1'b0, '0,
                                etbc_pkg::ST_OK, to_depth(cnt_r));
    tok_nc   = etbc_pkg::mk_tok(etbc_pkg::TK_NUM_END, etbc_pkg::CH_NUL, dec_seen_r, '0,
                                etbc_pkg::ST_OK, to_depth(cnt_r));
    tok_main = etbc_pkg::mk_tok(etbc_pkg::TK_INVALID, in_ch, 1'b0, '0,
                                etbc_pkg::ST_OK, to_depth(cnt_r));
    if (in_acc) begin
      if (halted_r) begin
        // halted line waits silently for the end of line
        if (is_end) begin
          started_nxt  = 1'b0;
          num_open_nxt = 1'b0;
          dec_seen_nxt = 1'b0;
          halted_nxt   = 1'b0;
          cnt_nxt      = '0;
        end
      end else begin
        if (!started_r) begin
          pre_v       = 1'b1;
          started_nxt = 1'b1;
        end
        priority if (is_ignored) begin
          main_v = 1'b0;
        end else if (is_end) begin
          nc_v         = num_open_r;
          main_v       = 1'b1;
          tok_main     = etbc_pkg::mk_tok(etbc_pkg::TK_END, etbc_pkg::CH_NUL, 1'b0, '0,
                                          etbc_pkg::ST_OK, '0);
          started_nxt  = 1'b0;
          num_open_nxt = 1'b0;
          dec_seen_nxt = 1'b0;
          cnt_nxt      = '0;
        end else if (is_op) begin
          nc_v          = num_open_r;
          num_open_nxt  = 1'b0;
          dec_seen_nxt  = 1'b0;
          main_v        = 1'b1;
          tok_main.kind = etbc_pkg::TK_OPERATOR;
          tok_main.prec = op_prec;
        end else if (is_num) begin
          main_v        = 1'b1;
          tok_main.kind = etbc_pkg::TK_NUM_CHAR;
          num_open_nxt  = 1'b1;
          if (in_ch == dec_pt_r) begin
            dec_seen_nxt = 1'b1;
          end
        end else if (is_open) begin
          nc_v          = num_open_r;
          num_open_nxt  = 1'b0;
          dec_seen_nxt  = 1'b0;
          main_v        = 1'b1;
          tok_main.kind = etbc_pkg::TK_OPEN;
          if (full) begin
            halted_nxt      = 1'b1;
            tok_main.status = etbc_pkg::ST_OVERFLOW;
          end else begin
            stk_ctl.push   = 1'b1;
            cnt_nxt        = cnt_r + CW'(1);
            tok_main.depth = to_depth(cnt_r + CW'(1));
          end
        end else if (is_close) begin
          nc_v          = num_open_r;
          num_open_nxt  = 1'b0;
          dec_seen_nxt  = 1'b0;
          main_v        = 1'b1;
          tok_main.kind = etbc_pkg::TK_CLOSE;
          priority if (cnt_r == '0) begin
            halted_nxt      = 1'b1;
            tok_main.status = etbc_pkg::ST_NO_OPEN;
          end else if (cell_code[0] != br_code) begin
            halted_nxt      = 1'b1;
            tok_main.status = etbc_pkg::ST_MISMATCH;
          end else begin
            stk_ctl.pop    = 1'b1;
            cnt_nxt        = cnt_r - CW'(1);
            tok_main.depth = to_depth(cnt_r - CW'(1));
          end
        end else begin
          main_v = 1'b1;
        end
      end
    end
  end

  // pack up to two tokens in order and mark the final one
  always_comb begin
    push_n = 2'(pre_v) + 2'(nc_v) + 2'(main_v);
    if (pre_v) begin
      q_a = tok_pre;
      q_b = nc_v ? tok_nc : tok_main;
    end else if (nc_v) begin
      q_a = tok_nc;
      q_b = tok_main;
    end else begin
      q_a = tok_main;
      q_b = tok_main;
    end
    if (push_n == 2'd1) begin
      q_a.last = 1'b1;
    end
    if (push_n == 2'd2) begin
      q_b.last = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      num_open_r <= 1'b0;
      dec_seen_r <= 1'b0;
      halted_r   <= 1'b0;
      cnt_r      <= '0;
      dec_pt_r   <= etbc_pkg::DEC_POINT_RESET;
    end else begin
      started_r  <= started_nxt;
      num_open_r <= num_open_nxt;
      dec_seen_r <= dec_seen_nxt;
      halted_r   <= halted_nxt;
      cnt_r      <= cnt_nxt;
      if (cfg_wr_en) begin
        dec_pt_r <= cfg_wr_data;
      end
    end
  end

  // bracket stack as a chain of cells, top of stack in cell 0
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [1:0] above;
    logic [1:0] below;
    if (g == 0) begin : g_top
      assign above = stk_ctl.code;
    end else begin : g_mid
      assign above = cell_code[g - 1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bot
      assign below = etbc_pkg::BR_ROUND;
    end else begin : g_nbot
      assign below = cell_code[g + 1];
    end
    etbc_cell u_cell (
      .clk        (clk),
      .ctl        (stk_ctl),
      .above_code (above),
      .below_code (below),
      .code_r     (cell_code[g])
    );
  end

  // result queue
  etbc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_a    (q_a),
    .push_b    (q_b),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  assign out_token_kind        = out_tok.kind;
  assign out_token_char        = out_tok.chr;
  assign out_number_is_decimal = out_tok.dec;
  assign out_precedence        = out_tok.prec;
  assign out_status            = out_tok.status;
  assign out_nesting_depth     = out_tok.depth;
  assign out_last              = out_tok.last;

  // checks
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && halted_r) |-> (push_n == 2'd0))
    else $error("halted line produced tokens");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(STACK_DEPTH)))
    else $error("bracket count beyond stack depth");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_end) |=> (!started_r && !halted_r && (cnt_r == '0)))
    else $error("end of line did not clear line state");

  a_fresh_token: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !halted_r && !started_r) |-> (push_n != 2'd0))
    else $error("new expression without opening token");

endmodule

`default_nettype wire

### tb/sv/expression_tokenizer_bracket_check_test.sv
module expression_tokenizer_bracket_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  import etbc_pkg::*;

  localparam int BRACKET_DEPTH = 64;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 100;
  localparam int POINT_PHASES  = 8;

  localparam logic [1:0] NO_PREC  = 2'd0;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_HIGH  = 8'hFF;

  // one pending request for the text channel
  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
    logic       hold;
  } text_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = 8'h00;
  logic       in_is_eof = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_token_kind;
  logic [7:0] out_token_char;
  logic       out_number_is_decimal;
  logic [1:0] out_precedence;
  logic [1:0] out_status;
  logic [6:0] out_nesting_depth;
  logic       out_last;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  expression_tokenizer_bracket_check #(
    .STACK_DEPTH(BRACKET_DEPTH)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_ch                (in_ch),
    .in_is_eof            (in_is_eof),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_token_kind       (out_token_kind),
    .out_token_char       (out_token_char),
    .out_number_is_decimal(out_number_is_decimal),
    .out_precedence       (out_precedence),
    .out_status           (out_status),
    .out_nesting_depth    (out_nesting_depth),
    .out_last             (out_last),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // lexer state mirrored in the bench
  logic [7:0] point_char = DEC_POINT_RESET;
  logic       expr_open = 1'b0;
  logic       num_open = 1'b0;
  logic       point_seen = 1'b0;
  logic       line_halted = 1'b0;
  logic [1:0] bracket_codes [BRACKET_DEPTH];
  int         open_count = 0;

  token_t     step_tokens [2];
  int         step_count;
  token_t     expected_tokens [$];
  text_req_t  pending_bytes [$];

  int         error_count = 0;
  int         checked_count = 0;
  int         queued_count = 0;

  // driver and receiver pacing
  logic       req_taken = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0] pattern_pos = 4'd0;
  int         pattern_left = 0;

  function automatic void clear_line();
    expr_open   = 1'b0;
    num_open    = 1'b0;
    point_seen  = 1'b0;
    line_halted = 1'b0;
    open_count  = 0;
  endfunction

  function automatic void add_token(tok_kind_t kind, logic [7:0] chr, logic dec,
                                    logic [1:0] prec, tok_status_t status);
    token_t t;
    t.kind   = kind;
    t.chr    = chr;
    t.dec    = dec;
    t.prec   = prec;
    t.status = status;
    t.depth  = open_count[6:0];
    t.last   = 1'b0;
    step_tokens[step_count] = t;
    step_count++;
  endfunction

  function automatic void end_number();
    if (num_open) begin
      add_token(TK_NUM_END, CH_NUL, point_seen, NO_PREC, ST_OK);
      num_open   = 1'b0;
      point_seen = 1'b0;
    end
  endfunction

  function automatic int op_rank(logic [7:0] c);
    case (c)
      CH_CARET:          return PREC_EXP;
      CH_STAR, CH_SLASH: return PREC_MUL;
      CH_PLUS, CH_MINUS: return PREC_ADD;
      default:           return -1;
    endcase
  endfunction

  function automatic int open_code(logic [7:0] c);
    case (c)
      CH_LPAREN: return BR_ROUND;
      CH_LSQ:    return BR_SQUARE;
      CH_LCURLY: return BR_CURLY;
      default:   return -1;
    endcase
  endfunction

  function automatic int close_code(logic [7:0] c);
    case (c)
      CH_RPAREN: return BR_ROUND;
      CH_RSQ:    return BR_SQUARE;
      CH_RCURLY: return BR_CURLY;
      default:   return -1;
    endcase
  endfunction

  // tokens caused by one accepted byte, appended to the expected list
  function automatic void lex_byte(logic [7:0] c, logic eof);
    logic line_end;
    logic letter;
    int   rank;
    int   ocode;
    int   ccode;
    int   i;
    line_end = eof || (c == CH_LF);
    letter   = (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    rank     = op_rank(c);
    ocode    = open_code(c);
    ccode    = close_code(c);
    step_count = 0;
    if (line_halted) begin
      if (line_end) clear_line();
    end else begin
      // implicit open bracket at the head of each expression
      if (!expr_open) begin
        add_token(TK_OPEN, CH_LPAREN, 1'b0, NO_PREC, ST_OK);
        expr_open = 1'b1;
      end
      if (!eof && (c == CH_SPACE || letter)) begin
        // skipped silently, an open number stays open
      end else if (line_end) begin
        end_number();
        open_count = 0;
        add_token(TK_END, CH_NUL, 1'b0, NO_PREC, ST_OK);
        clear_line();
      end else if (rank >= 0) begin
        end_number();
        add_token(TK_OPERATOR, c, 1'b0, rank[1:0], ST_OK);
      end else if ((c >= CH_ZERO && c <= CH_NINE) || c == point_char) begin
        if (c == point_char) point_seen = 1'b1;
        num_open = 1'b1;
        add_token(TK_NUM_CHAR, c, 1'b0, NO_PREC, ST_OK);
      end else if (ocode >= 0) begin
        end_number();
        if (open_count >= BRACKET_DEPTH) begin
          line_halted = 1'b1;
          add_token(TK_OPEN, c, 1'b0, NO_PREC, ST_OVERFLOW);
        end else begin
          bracket_codes[open_count] = ocode[1:0];
          open_count++;
          add_token(TK_OPEN, c, 1'b0, NO_PREC, ST_OK);
        end
      end else if (ccode >= 0) begin
        end_number();
        if (open_count == 0) begin
          line_halted = 1'b1;
          add_token(TK_CLOSE, c, 1'b0, NO_PREC, ST_NO_OPEN);
        end else if (bracket_codes[open_count - 1] != ccode[1:0]) begin
          line_halted = 1'b1;
          add_token(TK_CLOSE, c, 1'b0, NO_PREC, ST_MISMATCH);
        end else begin
          open_count--;
          add_token(TK_CLOSE, c, 1'b0, NO_PREC, ST_OK);
        end
      end else begin
        add_token(TK_INVALID, c, 1'b0, NO_PREC, ST_OK);
      end
    end
    for (i = 0; i < step_count; i++) begin
      if (i == step_count - 1) step_tokens[i].last = 1'b1;
      expected_tokens.push_back(step_tokens[i]);
    end
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // compare one accepted token with the oldest expected one
  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_error($sformatf("token %0d not expected: kind %0d char 0x%02h",
                             checked_count, out_token_kind, out_token_char));
    end else begin
      want = expected_tokens.pop_front();
      if (out_token_kind != want.kind)
        report_error($sformatf("token %0d kind: got %0d, want %0d",
                               checked_count, out_token_kind, want.kind));
      if (out_token_char != want.chr)
        report_error($sformatf("token %0d char: got 0x%02h, want 0x%02h",
                               checked_count, out_token_char, want.chr));
      if (out_number_is_decimal != want.dec)
        report_error($sformatf("token %0d decimal: got %0d, want %0d",
                               checked_count, out_number_is_decimal, want.dec));
      if (out_precedence != want.prec)
        report_error($sformatf("token %0d precedence: got %0d, want %0d",
                               checked_count, out_precedence, want.prec));
      if (out_status != want.status)
        report_error($sformatf("token %0d status: got %0d, want %0d",
                               checked_count, out_status, want.status));
      if (out_nesting_depth != want.depth)
        report_error($sformatf("token %0d depth: got %0d, want %0d",
                               checked_count, out_nesting_depth, want.depth));
      if (out_last != want.last)
        report_error($sformatf("token %0d last: got %0d, want %0d",
                               checked_count, out_last, want.last));
    end
    checked_count++;
  endtask

  // accepted requests feed the predictor, accepted tokens get checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        lex_byte(in_ch, in_is_eof);
        pending_bytes.delete(0);
        req_taken = 1'b1;
      end
      if (out_valid && out_ready) check_token();
    end
  end

  // request driver: bursts with random gaps, held items wait for a full drain
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_bytes.size() > 0 &&
                   !(pending_bytes[0].hold && expected_tokens.size() > 0)) begin
        in_valid  <= 1'b1;
        in_ch     <= pending_bytes[0].ch;
        in_is_eof <= pending_bytes[0].eof;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stalls from a rotating 16-bit pattern
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = 16'hFFFF;
        1:       ready_pattern = 16'($urandom) | 16'h0001;
        2:       ready_pattern = 16'h5555;
        default: ready_pattern = 16'h8421;
      endcase
      pattern_left = $urandom_range(16, 200);
    end
    pattern_left--;
    out_ready <= ready_pattern[pattern_pos];
    pattern_pos <= pattern_pos + 4'd1;
  end

  function automatic void put(logic [7:0] c, logic eof);
    text_req_t r;
    r.ch   = c;
    r.eof  = eof;
    r.hold = ($urandom_range(0, 199) == 0);
    pending_bytes.push_back(r);
    queued_count++;
  endfunction

  function automatic logic [7:0] open_char(logic [1:0] code);
    case (code)
      BR_ROUND:  return CH_LPAREN;
      BR_SQUARE: return CH_LSQ;
      default:   return CH_LCURLY;
    endcase
  endfunction

  function automatic logic [7:0] close_char(logic [1:0] code);
    case (code)
      BR_ROUND:  return CH_RPAREN;
      BR_SQUARE: return CH_RSQ;
      default:   return CH_RCURLY;
    endcase
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 4))
      0:       return CH_CARET;
      1:       return CH_STAR;
      2:       return CH_SLASH;
      3:       return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  function automatic logic [7:0] random_letter();
    return (($urandom_range(0, 1) != 0) ? CH_LC_A : CH_UC_A) + 8'($urandom_range(0, 25));
  endfunction

  // digits with an optional decimal point and an occasional suffix letter
  function automatic void gen_number();
    int len;
    int point_at;
    int k;
    len      = $urandom_range(1, 4);
    point_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : -1;
    for (k = 0; k <= len; k++) begin
      if (k == point_at) put(point_char, 1'b0);
      if (k < len) put(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end
    if ($urandom_range(0, 7) == 0) put(CH_LC_F, 1'b0);
  endfunction

  // mostly well-formed expression line with some noise and broken closes
  function automatic void gen_line(int max_open);
    logic [1:0] opens [$];
    logic [1:0] code;
    int         steps;
    int         pick;
    int         k;
    steps = $urandom_range(1, 16);
    for (k = 0; k < steps; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        gen_number();
      end else if (pick < 48) begin
        put(random_op(), 1'b0);
      end else if (pick < 62 && opens.size() < max_open) begin
        code = 2'($urandom_range(0, 2));
        opens.push_back(code);
        put(open_char(code), 1'b0);
      end else if (pick < 78 && opens.size() > 0) begin
        put(close_char(opens.pop_back()), 1'b0);
      end else if (pick < 88) begin
        put(($urandom_range(0, 1) != 0) ? CH_SPACE : random_letter(), 1'b0);
      end else if (pick < 94) begin
        put(8'($urandom), 1'b0);
      end else if (pick < 97) begin
        put(close_char(2'($urandom_range(0, 2))), 1'b0);
      end else begin
        put(random_op(), 1'b0);
      end
    end
    if ($urandom_range(0, 3) != 0)
      while (opens.size() > 0) put(close_char(opens.pop_back()), 1'b0);
    if ($urandom_range(0, 3) == 0) put(8'($urandom), 1'b1);
    else put(CH_LF, 1'b0);
  endfunction

  // fill the bracket stack, then unwind it or push one too many
  function automatic void gen_deep(logic over);
    logic [1:0] opens [$];
    logic [1:0] code;
    int         k;
    for (k = 0; k < BRACKET_DEPTH; k++) begin
      code = 2'($urandom_range(0, 2));
      opens.push_back(code);
      put(open_char(code), 1'b0);
      if ($urandom_range(0, 7) == 0) gen_number();
    end
    if (over) begin
      put(open_char(2'($urandom_range(0, 2))), 1'b0);
      put(CH_ZERO, 1'b0);
      put(close_char(opens[$]), 1'b0);
    end else begin
      while (opens.size() > 0) put(close_char(opens.pop_back()), 1'b0);
    end
    put(CH_LF, 1'b0);
  endfunction

  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((pending_bytes.size() != 0 || in_valid || expected_tokens.size() != 0) &&
           guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_point(logic [7:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    point_char   = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(int phase);
    int start;
    int pick;
    int k;
    start = queued_count;
    gen_deep(phase % 2 == 1);
    while (queued_count - start < PHASE_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        gen_line($urandom_range(1, 8));
      end else if (pick < 18) begin
        for (k = $urandom_range(1, 10); k > 0; k--)
          put(8'($urandom), $urandom_range(0, 11) == 0);
      end else begin
        gen_line($urandom_range(9, 30));
      end
    end
    wait_idle();
  endtask

  function automatic logic [7:0] point_setting(int idx);
    case (idx)
      0:       return 8'h00;
      1:       return CH_HIGH;
      2:       return CH_COMMA;
      3:       return CH_LPAREN;
      4:       return CH_LC_E;
      5:       return CH_PLUS;
      6:       return 8'($urandom);
      default: return DEC_POINT_RESET;
    endcase
  endfunction

  // main sequence
  initial begin
    int p;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed line: numbers, operators, brackets, skipped bytes, errors
    put(CH_SPACE, 1'b0);
    put(CH_NINE, 1'b0);
    put(CH_LC_A, 1'b0);
    put(DEC_POINT_RESET, 1'b0);
    put(DEC_POINT_RESET, 1'b0);
    put(CH_HIGH, 1'b0);
    put(CH_ZERO, 1'b0);
    put(CH_STAR, 1'b0);
    put(CH_LPAREN, 1'b0);
    put(CH_LSQ, 1'b0);
    put(CH_LCURLY, 1'b0);
    put(CH_RCURLY, 1'b0);
    put(CH_SLASH, 1'b0);
    put(CH_PLUS, 1'b0);
    put(CH_MINUS, 1'b0);
    put(CH_CARET, 1'b0);
    put(CH_RSQ, 1'b0);
    put(CH_ZERO + 8'd7, 1'b0);
    put(CH_RPAREN, 1'b0);
    // close with nothing open halts the line until newline
    put(CH_RPAREN, 1'b0);
    put(CH_ZERO + 8'd5, 1'b0);
    put(CH_LF, 1'b0);
    // mismatched close, then end of input clears the halted line
    put(CH_LPAREN, 1'b0);
    put(CH_RSQ, 1'b0);
    put(CH_HIGH, 1'b1);
    // end of input as the first byte, then a nul byte
    put(CH_UC_A, 1'b1);
    put(CH_NUL, 1'b0);
    put(CH_ZERO + 8'd3, 1'b0);
    put(CH_LF, 1'b0);
    wait_idle();

    run_phase(0);
    for (p = 0; p < POINT_PHASES; p++) begin
      write_point(point_setting(p));
      run_phase(p + 1);
    end

    if (expected_tokens.size() != 0)
      report_error($sformatf("%0d expected tokens never arrived", expected_tokens.size()));
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
